FILE: rtl/core/etok_pkg.sv
// ----------------------------------------------------------------------------
// etok_pkg
// Types and constants shared by the expression tokenizer modules.
// ----------------------------------------------------------------------------
package etok_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam int CHAR_W = 21;

    typedef enum logic [6:0] {
        M_IDLE  = 7'b0000001,
        M_IDENT = 7'b0000010,
        M_INT   = 7'b0000100,
        M_FLOAT = 7'b0001000,
        M_STR   = 7'b0010000,
        M_QUOTE = 7'b0100000,
        M_ERROR = 7'b1000000
    } t_mode;

    localparam logic [2:0] TY_IDENT = 3'd0;
    localparam logic [2:0] TY_INT   = 3'd1;
    localparam logic [2:0] TY_FLOAT = 3'd2;
    localparam logic [2:0] TY_STR   = 3'd3;
    localparam logic [2:0] TY_OPEN  = 3'd4;
    localparam logic [2:0] TY_CLOSE = 3'd5;
    localparam logic [2:0] TY_COMMA = 3'd6;
    localparam logic [2:0] TY_EQUAL = 3'd7;

    localparam logic [2:0] E_BAD_START = 3'd0;
    localparam logic [2:0] E_BAD_DELIM = 3'd1;
    localparam logic [2:0] E_SECOND_PT = 3'd2;
    localparam logic [2:0] E_STR_CTRL  = 3'd3;
    localparam logic [2:0] E_UNTERM    = 3'd4;

    localparam logic [CHAR_W-1:0] C_TAB        = 21'd9;
    localparam logic [CHAR_W-1:0] C_CR         = 21'd13;
    localparam logic [CHAR_W-1:0] C_SPACE      = 21'd32;
    localparam logic [CHAR_W-1:0] C_QUOTE      = 21'd39;
    localparam logic [CHAR_W-1:0] C_OPEN       = 21'd40;
    localparam logic [CHAR_W-1:0] C_CLOSE      = 21'd41;
    localparam logic [CHAR_W-1:0] C_PLUS       = 21'd43;
    localparam logic [CHAR_W-1:0] C_COMMA      = 21'd44;
    localparam logic [CHAR_W-1:0] C_MINUS      = 21'd45;
    localparam logic [CHAR_W-1:0] C_POINT      = 21'd46;
    localparam logic [CHAR_W-1:0] C_DIGIT_LO   = 21'd48;
    localparam logic [CHAR_W-1:0] C_DIGIT_HI   = 21'd57;
    localparam logic [CHAR_W-1:0] C_EQUAL      = 21'd61;
    localparam logic [CHAR_W-1:0] C_UPPER_LO   = 21'd65;
    localparam logic [CHAR_W-1:0] C_UPPER_HI   = 21'd90;
    localparam logic [CHAR_W-1:0] C_UNDERSCORE = 21'd95;
    localparam logic [CHAR_W-1:0] C_LOWER_LO   = 21'd97;
    localparam logic [CHAR_W-1:0] C_LOWER_HI   = 21'd122;
    localparam logic [CHAR_W-1:0] C_HIGH       = 21'd128;

    typedef struct packed {
        logic [2:0]        token_type;
        logic [CHAR_W-1:0] token_char;
        logic              has_char;
        logic              token_end;
        logic              error_flag;
        logic [2:0]        error_code;
        logic              run_end;
    } t_result;

    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
        t_mode      mode;
    } t_step;

endpackage

FILE: rtl/core/etok_classify.sv
// ----------------------------------------------------------------------------
// etok_classify
// Single-step lexer logic: current mode and one character give the next mode
// and up to two result items.
// ----------------------------------------------------------------------------
module etok_classify (
    input  etok_pkg::t_mode              i_mode,
    input  logic [etok_pkg::CHAR_W-1:0]  i_char,
    input  logic                         i_eom,
    output etok_pkg::t_step              o_step
);

    function automatic logic f_is_space(input logic [etok_pkg::CHAR_W-1:0] c);
        return (c == etok_pkg::C_SPACE) || (c inside {[etok_pkg::C_TAB:etok_pkg::C_CR]});
    endfunction

    function automatic logic f_is_digit(input logic [etok_pkg::CHAR_W-1:0] c);
        return c inside {[etok_pkg::C_DIGIT_LO:etok_pkg::C_DIGIT_HI]};
    endfunction

    function automatic logic f_is_ident_start(input logic [etok_pkg::CHAR_W-1:0] c);
        return (c > etok_pkg::C_HIGH) || (c == etok_pkg::C_UNDERSCORE)
            || (c inside {[etok_pkg::C_UPPER_LO:etok_pkg::C_UPPER_HI],
                          [etok_pkg::C_LOWER_LO:etok_pkg::C_LOWER_HI]});
    endfunction

    function automatic logic f_is_delim(input logic [etok_pkg::CHAR_W-1:0] c);
        return f_is_space(c) || (c inside {etok_pkg::C_OPEN, etok_pkg::C_CLOSE,
                                           etok_pkg::C_COMMA, etok_pkg::C_EQUAL});
    endfunction

    function automatic etok_pkg::t_result f_char(input logic [2:0] ty,
                                                 input logic [etok_pkg::CHAR_W-1:0] c);
        etok_pkg::t_result r;
        r            = '0;
        r.token_type = ty;
        r.token_char = c;
        r.has_char   = 1'b1;
        return r;
    endfunction

    function automatic etok_pkg::t_result f_end(input logic [2:0] ty);
        etok_pkg::t_result r;
        r            = '0;
        r.token_type = ty;
        r.token_end  = 1'b1;
        return r;
    endfunction

    function automatic etok_pkg::t_result f_err(input logic [2:0] code);
        etok_pkg::t_result r;
        r            = '0;
        r.error_flag = 1'b1;
        r.error_code = code;
        return r;
    endfunction

    // idle handling: result lands in r0, cnt is 0 or 1
    function automatic etok_pkg::t_step f_idle(input logic [etok_pkg::CHAR_W-1:0] c);
        etok_pkg::t_step s;
        s      = '0;
        s.mode = etok_pkg::M_IDLE;
        s.cnt  = 2'd1;
        if (f_is_ident_start(c)) begin
            s.r0   = f_char(etok_pkg::TY_IDENT, c);
            s.mode = etok_pkg::M_IDENT;
        end else if (f_is_digit(c) || c == etok_pkg::C_PLUS || c == etok_pkg::C_MINUS) begin
            s.r0   = f_char(etok_pkg::TY_INT, c);
            s.mode = etok_pkg::M_INT;
        end else if (f_is_space(c)) begin
            s.cnt = 2'd0;
        end else if (c == etok_pkg::C_QUOTE) begin
            s.cnt  = 2'd0;
            s.mode = etok_pkg::M_STR;
        end else if (c == etok_pkg::C_OPEN) begin
            s.r0 = f_end(etok_pkg::TY_OPEN);
        end else if (c == etok_pkg::C_CLOSE) begin
            s.r0 = f_end(etok_pkg::TY_CLOSE);
        end else if (c == etok_pkg::C_COMMA) begin
            s.r0 = f_end(etok_pkg::TY_COMMA);
        end else if (c == etok_pkg::C_EQUAL) begin
            s.r0 = f_end(etok_pkg::TY_EQUAL);
        end else begin
            s.r0   = f_err(etok_pkg::E_BAD_START);
            s.mode = etok_pkg::M_ERROR;
        end
        return s;
    endfunction

    function automatic etok_pkg::t_step f_close(input logic [2:0] ty,
                                                input logic [etok_pkg::CHAR_W-1:0] c);
        etok_pkg::t_step s;
        etok_pkg::t_step idl;
        s   = '0;
        idl = f_idle(c);
        if (f_is_delim(c)) begin
            s.r0   = f_end(ty);
            s.r1   = idl.r0;
            s.cnt  = idl.cnt + 2'd1;
            s.mode = idl.mode;
        end else begin
            s.r0   = f_err(etok_pkg::E_BAD_DELIM);
            s.cnt  = 2'd1;
            s.mode = etok_pkg::M_ERROR;
        end
        return s;
    endfunction

    etok_pkg::t_step s;

    always_comb begin
        s      = '0;
        s.mode = i_mode;
        if (i_eom) begin
            s.mode = etok_pkg::M_IDLE;
            s.cnt  = 2'd1;
            case (i_mode)
                etok_pkg::M_IDENT: s.r0 = f_end(etok_pkg::TY_IDENT);
                etok_pkg::M_INT:   s.r0 = f_end(etok_pkg::TY_INT);
                etok_pkg::M_FLOAT: s.r0 = f_end(etok_pkg::TY_FLOAT);
                etok_pkg::M_QUOTE: s.r0 = f_end(etok_pkg::TY_STR);
                etok_pkg::M_STR:   s.r0 = f_err(etok_pkg::E_UNTERM);
                default:           s.cnt = 2'd0;
            endcase
        end else begin
            case (i_mode)
                etok_pkg::M_IDLE: begin
                    s = f_idle(i_char);
                end
                etok_pkg::M_IDENT: begin
                    if (f_is_ident_start(i_char) || f_is_digit(i_char)) begin
                        s.r0  = f_char(etok_pkg::TY_IDENT, i_char);
                        s.cnt = 2'd1;
                    end else begin
                        s = f_close(etok_pkg::TY_IDENT, i_char);
                    end
                end
                etok_pkg::M_INT: begin
                    if (f_is_digit(i_char)) begin
                        s.r0  = f_char(etok_pkg::TY_INT, i_char);
                        s.cnt = 2'd1;
                    end else if (i_char == etok_pkg::C_POINT) begin
                        s.r0   = f_char(etok_pkg::TY_FLOAT, i_char);
                        s.cnt  = 2'd1;
                        s.mode = etok_pkg::M_FLOAT;
                    end else begin
                        s = f_close(etok_pkg::TY_INT, i_char);
                    end
                end
                etok_pkg::M_FLOAT: begin
                    if (f_is_digit(i_char)) begin
                        s.r0  = f_char(etok_pkg::TY_FLOAT, i_char);
                        s.cnt = 2'd1;
                    end else if (i_char == etok_pkg::C_POINT) begin
                        s.r0   = f_err(etok_pkg::E_SECOND_PT);
                        s.cnt  = 2'd1;
                        s.mode = etok_pkg::M_ERROR;
                    end else begin
                        s = f_close(etok_pkg::TY_FLOAT, i_char);
                    end
                end
                etok_pkg::M_STR: begin
                    if (i_char == etok_pkg::C_QUOTE) begin
                        s.mode = etok_pkg::M_QUOTE;
                    end else if (i_char < etok_pkg::C_SPACE) begin
                        s.r0   = f_err(etok_pkg::E_STR_CTRL);
                        s.cnt  = 2'd1;
                        s.mode = etok_pkg::M_ERROR;
                    end else begin
                        s.r0  = f_char(etok_pkg::TY_STR, i_char);
                        s.cnt = 2'd1;
                    end
                end
                etok_pkg::M_QUOTE: begin
                    if (i_char == etok_pkg::C_QUOTE) begin
                        s.r0   = f_char(etok_pkg::TY_STR, i_char);
                        s.cnt  = 2'd1;
                        s.mode = etok_pkg::M_STR;
                    end else begin
                        s = f_close(etok_pkg::TY_STR, i_char);
                    end
                end
                default: begin
                    s.mode = etok_pkg::M_ERROR;
                end
            endcase
        end
    end

    always_comb begin
        o_step = s;
        if (s.cnt == 2'd1) begin
            o_step.r0.run_end = 1'b1;
        end
        if (s.cnt == 2'd2) begin
            o_step.r1.run_end = 1'b1;
        end
    end

endmodule

FILE: rtl/core/etok_out_queue.sv
// ----------------------------------------------------------------------------
// etok_out_queue
// Small result queue: takes up to two results per cycle, delivers one while i_ready is high.
// ----------------------------------------------------------------------------
module etok_out_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  etok_pkg::t_step     i_step,
    output logic                o_space,
    output logic                o_valid,
    input  logic                i_ready,
    output etok_pkg::t_result   o_item
);

    etok_pkg::t_result              r_mem [etok_pkg::QDEPTH];
    logic [etok_pkg::QPTR_W-1:0]    r_head;
    logic [etok_pkg::QPTR_W-1:0]    r_tail;
    logic [etok_pkg::QPTR_W:0]      r_count;
    logic [etok_pkg::QPTR_W:0]      n_count;
    logic [etok_pkg::QPTR_W-1:0]    n_tail;
    logic [etok_pkg::QPTR_W:0]      push_cnt;
    logic                           pop;

    assign pop      = o_valid && i_ready;
    assign push_cnt = i_push ? (etok_pkg::QPTR_W+1)'(i_step.cnt) : '0;
    assign n_count  = r_count + push_cnt - (etok_pkg::QPTR_W+1)'(pop);
    assign n_tail   = r_tail + push_cnt[etok_pkg::QPTR_W-1:0];
    assign o_space  = r_count <= (etok_pkg::QPTR_W+1)'(etok_pkg::QDEPTH - 2);
    assign o_valid  = r_count != '0;
    assign o_item   = r_mem[r_head];

    always_ff @(posedge i_clk) begin
        if (i_push && i_step.cnt != 2'd0) begin
            r_mem[r_tail] <= i_step.r0;
        end
        if (i_push && i_step.cnt == 2'd2) begin
            r_mem[r_tail + etok_pkg::QPTR_W'(1)] <= i_step.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= n_tail;
            r_count <= n_count;
            if (pop) begin
                r_head <= r_head + etok_pkg::QPTR_W'(1);
            end
        end
    end

endmodule

FILE: rtl/core/expression_tokenizer.sv
// ----------------------------------------------------------------------------
// expression_tokenizer
// Streaming lexer for expressions: identifiers, numbers, quoted strings and
// bracket, comma and equal tokens.
// ----------------------------------------------------------------------------
// Each character transfer on the slave side is registered, then lexed against
// the mode register, and its zero, one or two results enter a four-entry
// output queue. A new character is taken every cycle while the queue has room
// for two results, so the sustained rate is one character per cycle whenever
// each character yields at most one result and the master side is ready; a
// character that ends a word token and is itself a bracket, comma or equal
// yields two results, and the master side then drains them one at a time.
// A result reaches the master side through the input register and the output
// queue. tlast on the slave side marks the end of a message; tlast on the
// master side marks the last result of a character.
module expression_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [20:0] char_code
    input  logic        i_s_axis_tlast,   // end_of_message
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [20:0] token_char, [21] has_char, [22] token_end, [23] error_flag,
    // [26:24] error_code
    output logic [31:0] o_m_axis_tdata,
    output logic [2:0]  o_m_axis_tuser,   // [2:0] token_type
    output logic        o_m_axis_tlast    // run_end
);

    logic                          r_in_valid;
    logic [etok_pkg::CHAR_W-1:0]   r_in_char;
    logic                          r_in_eom;
    etok_pkg::t_mode               r_mode;
    etok_pkg::t_step               step;
    etok_pkg::t_result             item;
    logic                          space;
    logic                          adv;

    assign adv             = r_in_valid && space;
    assign o_s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_char <= i_s_axis_tdata[etok_pkg::CHAR_W-1:0];
            r_in_eom  <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= etok_pkg::M_IDLE;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (adv) begin
                r_mode <= step.mode;
            end
        end
    end

    etok_classify u_classify (
        .i_mode (r_mode),
        .i_char (r_in_char),
        .i_eom  (r_in_eom),
        .o_step (step)
    );

    etok_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (adv),
        .i_step  (step),
        .o_space (space),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_item  (item)
    );

    assign o_m_axis_tdata = {5'd0, item.error_code, item.error_flag, item.token_end,
                             item.has_char, item.token_char};
    assign o_m_axis_tuser = item.token_type;
    assign o_m_axis_tlast = item.run_end;

endmodule

FILE: tb/expression_tokenizer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// expression_tokenizer_test
// Self-checking bench for the streaming expression lexer. Characters go in on
// the slave stream; a lexer model in the bench predicts every token result,
// and each result transfer on the master stream is checked in order. A
// directed pass covers the token kinds and error paths, then random messages
// run under several idle and stall mixes plus a long output hold-off.
// ----------------------------------------------------------------------------
module expression_tokenizer_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam logic [etok_pkg::CHAR_W-1:0] C_TOP = 21'h10FFFF;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [23:0]       i_s_axis_tdata = '0;   // [20:0] char_code
    logic              i_s_axis_tlast = 1'b0; // end_of_message
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    // [20:0] token_char, [21] has_char, [22] token_end, [23] error_flag,
    // [26:24] error_code
    logic [31:0]       o_m_axis_tdata;
    logic [2:0]        o_m_axis_tuser;        // [2:0] token_type
    logic              o_m_axis_tlast;        // run_end

    etok_pkg::t_mode   lex_mode = etok_pkg::M_IDLE;
    etok_pkg::t_result step_results[$];
    etok_pkg::t_result expected_tokens[$];
    int                chars_sent = 0;
    int                mismatch_count = 0;
    int                cycle_count = 0;
    int                send_gap_pct = 0;
    int                recv_stall_pct = 0;
    int                hold_cycles = 0;

    expression_tokenizer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("expression_tokenizer_test: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Lexer model
    // ------------------------------------------------------------------------
    function automatic logic [etok_pkg::CHAR_W-1:0] to_char(int unsigned v);
        return etok_pkg::CHAR_W'(v);
    endfunction

    function automatic bit is_space(logic [etok_pkg::CHAR_W-1:0] c);
        return c == etok_pkg::C_SPACE || (c >= etok_pkg::C_TAB && c <= etok_pkg::C_CR);
    endfunction

    function automatic bit is_digit(logic [etok_pkg::CHAR_W-1:0] c);
        return c >= etok_pkg::C_DIGIT_LO && c <= etok_pkg::C_DIGIT_HI;
    endfunction

    function automatic bit is_ident_start(logic [etok_pkg::CHAR_W-1:0] c);
        return c > etok_pkg::C_HIGH || c == etok_pkg::C_UNDERSCORE
            || (c >= etok_pkg::C_LOWER_LO && c <= etok_pkg::C_LOWER_HI)
            || (c >= etok_pkg::C_UPPER_LO && c <= etok_pkg::C_UPPER_HI);
    endfunction

    function automatic bit is_delim(logic [etok_pkg::CHAR_W-1:0] c);
        return c == etok_pkg::C_OPEN || c == etok_pkg::C_CLOSE
            || c == etok_pkg::C_COMMA || c == etok_pkg::C_EQUAL
            || is_space(c);
    endfunction

    function automatic void add_result(logic [2:0] ty, logic [etok_pkg::CHAR_W-1:0] ch,
                                       logic has, logic fin, logic err,
                                       logic [2:0] code);
        etok_pkg::t_result r;
        r.token_type = ty;
        r.token_char = has ? ch : '0;
        r.has_char   = has;
        r.token_end  = fin;
        r.error_flag = err;
        r.error_code = err ? code : '0;
        r.run_end    = 1'b0;
        step_results.insert(step_results.size(), r);
    endfunction

    function automatic void raise_error(logic [2:0] code);
        add_result(etok_pkg::TY_IDENT, '0, 1'b0, 1'b0, 1'b1, code);
        lex_mode = etok_pkg::M_ERROR;
    endfunction

    function automatic void start_token(logic [etok_pkg::CHAR_W-1:0] c);
        if (is_ident_start(c)) begin
            add_result(etok_pkg::TY_IDENT, c, 1'b1, 1'b0, 1'b0, etok_pkg::E_BAD_START);
            lex_mode = etok_pkg::M_IDENT;
        end else if (is_digit(c) || c == etok_pkg::C_PLUS || c == etok_pkg::C_MINUS) begin
            add_result(etok_pkg::TY_INT, c, 1'b1, 1'b0, 1'b0, etok_pkg::E_BAD_START);
            lex_mode = etok_pkg::M_INT;
        end else if (is_space(c)) begin
        end else if (c == etok_pkg::C_QUOTE) begin
            lex_mode = etok_pkg::M_STR;
        end else if (c == etok_pkg::C_OPEN) begin
            add_result(etok_pkg::TY_OPEN, '0, 1'b0, 1'b1, 1'b0, etok_pkg::E_BAD_START);
        end else if (c == etok_pkg::C_CLOSE) begin
            add_result(etok_pkg::TY_CLOSE, '0, 1'b0, 1'b1, 1'b0, etok_pkg::E_BAD_START);
        end else if (c == etok_pkg::C_COMMA) begin
            add_result(etok_pkg::TY_COMMA, '0, 1'b0, 1'b1, 1'b0, etok_pkg::E_BAD_START);
        end else if (c == etok_pkg::C_EQUAL) begin
            add_result(etok_pkg::TY_EQUAL, '0, 1'b0, 1'b1, 1'b0, etok_pkg::E_BAD_START);
        end else begin
            raise_error(etok_pkg::E_BAD_START);
        end
    endfunction

    // End a word token at c, then treat c as the start of what follows.
    function automatic void close_token(logic [2:0] ty, logic [etok_pkg::CHAR_W-1:0] c);
        if (is_delim(c)) begin
            add_result(ty, '0, 1'b0, 1'b1, 1'b0, etok_pkg::E_BAD_START);
            lex_mode = etok_pkg::M_IDLE;
            start_token(c);
        end else begin
            raise_error(etok_pkg::E_BAD_DELIM);
        end
    endfunction

    function automatic void lex_char(logic [etok_pkg::CHAR_W-1:0] c, logic eom);
        step_results.delete();
        if (eom) begin
            case (lex_mode)
                etok_pkg::M_IDENT:
                    add_result(etok_pkg::TY_IDENT, '0, 1'b0, 1'b1, 1'b0,
                               etok_pkg::E_BAD_START);
                etok_pkg::M_INT:
                    add_result(etok_pkg::TY_INT, '0, 1'b0, 1'b1, 1'b0,
                               etok_pkg::E_BAD_START);
                etok_pkg::M_FLOAT:
                    add_result(etok_pkg::TY_FLOAT, '0, 1'b0, 1'b1, 1'b0,
                               etok_pkg::E_BAD_START);
                etok_pkg::M_QUOTE:
                    add_result(etok_pkg::TY_STR, '0, 1'b0, 1'b1, 1'b0,
                               etok_pkg::E_BAD_START);
                etok_pkg::M_STR:
                    add_result(etok_pkg::TY_IDENT, '0, 1'b0, 1'b0, 1'b1,
                               etok_pkg::E_UNTERM);
                default: begin
                end
            endcase
            lex_mode = etok_pkg::M_IDLE;
        end else begin
            case (lex_mode)
                etok_pkg::M_IDLE: start_token(c);
                etok_pkg::M_IDENT: begin
                    if (is_ident_start(c) || is_digit(c))
                        add_result(etok_pkg::TY_IDENT, c, 1'b1, 1'b0, 1'b0,
                                   etok_pkg::E_BAD_START);
                    else
                        close_token(etok_pkg::TY_IDENT, c);
                end
                etok_pkg::M_INT: begin
                    if (is_digit(c)) begin
                        add_result(etok_pkg::TY_INT, c, 1'b1, 1'b0, 1'b0,
                                   etok_pkg::E_BAD_START);
                    end else if (c == etok_pkg::C_POINT) begin
                        add_result(etok_pkg::TY_FLOAT, c, 1'b1, 1'b0, 1'b0,
                                   etok_pkg::E_BAD_START);
                        lex_mode = etok_pkg::M_FLOAT;
                    end else begin
                        close_token(etok_pkg::TY_INT, c);
                    end
                end
                etok_pkg::M_FLOAT: begin
                    if (is_digit(c))
                        add_result(etok_pkg::TY_FLOAT, c, 1'b1, 1'b0, 1'b0,
                                   etok_pkg::E_BAD_START);
                    else if (c == etok_pkg::C_POINT)
                        raise_error(etok_pkg::E_SECOND_PT);
                    else
                        close_token(etok_pkg::TY_FLOAT, c);
                end
                etok_pkg::M_STR: begin
                    if (c == etok_pkg::C_QUOTE)
                        lex_mode = etok_pkg::M_QUOTE;
                    else if (c < etok_pkg::C_SPACE)
                        raise_error(etok_pkg::E_STR_CTRL);
                    else
                        add_result(etok_pkg::TY_STR, c, 1'b1, 1'b0, 1'b0,
                                   etok_pkg::E_BAD_START);
                end
                etok_pkg::M_QUOTE: begin
                    if (c == etok_pkg::C_QUOTE) begin
                        add_result(etok_pkg::TY_STR, c, 1'b1, 1'b0, 1'b0,
                                   etok_pkg::E_BAD_START);
                        lex_mode = etok_pkg::M_STR;
                    end else begin
                        close_token(etok_pkg::TY_STR, c);
                    end
                end
                default: lex_mode = etok_pkg::M_ERROR;
            endcase
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].run_end = 1'b1;
        foreach (step_results[i])
            expected_tokens.insert(expected_tokens.size(), step_results[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    // Entered and left at a falling edge; tvalid stays high on return.
    task automatic send_item(logic [etok_pkg::CHAR_W-1:0] c, logic eom);
        while ($urandom_range(99) < send_gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {3'b000, c};
        i_s_axis_tlast  <= eom;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
        chars_sent++;
        lex_char(c, eom);
    endtask

    // Drop tvalid and hold until every predicted result has arrived or DRAIN_LIMIT runs out.
    task automatic wait_results_done();
        int waited;
        waited = 0;
        i_s_axis_tvalid <= 1'b0;
        while (expected_tokens.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_idling(int gap_pct, int stall_pct, int hold);
        @(posedge i_clk);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        hold_cycles    = hold;
        @(negedge i_clk);
    endtask

    function automatic logic [etok_pkg::CHAR_W-1:0] pick_digit();
        return to_char(etok_pkg::C_DIGIT_LO + $urandom_range(9));
    endfunction

    function automatic logic [etok_pkg::CHAR_W-1:0] pick_high();
        return to_char($urandom_range(1114111, 129));
    endfunction

    function automatic logic [etok_pkg::CHAR_W-1:0] pick_ident_char(bit first);
        int r;
        r = $urandom_range(first ? 9 : 12);
        if (r < 3) return to_char(etok_pkg::C_LOWER_LO + $urandom_range(25));
        if (r < 6) return to_char(etok_pkg::C_UPPER_LO + $urandom_range(25));
        if (r == 6) return etok_pkg::C_UNDERSCORE;
        if (r < 9) return pick_high();
        if (r == 9) return $urandom_range(1) ? C_TOP : to_char(etok_pkg::C_HIGH + 1);
        return pick_digit();
    endfunction

    function automatic logic [etok_pkg::CHAR_W-1:0] pick_punct();
        case ($urandom_range(3))
            0: return etok_pkg::C_OPEN;
            1: return etok_pkg::C_CLOSE;
            2: return etok_pkg::C_COMMA;
            default: return etok_pkg::C_EQUAL;
        endcase
    endfunction

    function automatic logic [etok_pkg::CHAR_W-1:0] pick_noise();
        case ($urandom_range(9))
            0, 1, 2, 3: return to_char($urandom_range(1114111, 0));
            4, 5, 6: return to_char($urandom_range(127, 0));
            7: return etok_pkg::C_HIGH;
            8: return '0;
            default: return C_TOP;
        endcase
    endfunction

    task automatic send_ident();
        send_item(pick_ident_char(1'b1), 1'b0);
        repeat ($urandom_range(5, 0)) send_item(pick_ident_char(1'b0), 1'b0);
    endtask

    task automatic send_number();
        int r;
        r = $urandom_range(9);
        send_item(r < 7 ? pick_digit() : (r == 7 ? etok_pkg::C_PLUS : etok_pkg::C_MINUS),
                  1'b0);
        repeat ($urandom_range(4, 0)) send_item(pick_digit(), 1'b0);
        if ($urandom_range(9) < 4) begin
            send_item(etok_pkg::C_POINT, 1'b0);
            repeat ($urandom_range(3, 0)) send_item(pick_digit(), 1'b0);
            if ($urandom_range(19) == 0)
                send_item(etok_pkg::C_POINT, 1'b0);
        end
    endtask

    task automatic send_string();
        int r;
        logic [etok_pkg::CHAR_W-1:0] c;
        send_item(etok_pkg::C_QUOTE, 1'b0);
        repeat ($urandom_range(6, 0)) begin
            r = $urandom_range(99);
            if (r < 10) begin
                send_item(etok_pkg::C_QUOTE, 1'b0);
                send_item(etok_pkg::C_QUOTE, 1'b0);
            end else if (r < 13) begin
                send_item(to_char($urandom_range(31, 0)), 1'b0);
            end else if (r < 30) begin
                send_item(pick_high(), 1'b0);
            end else begin
                c = to_char($urandom_range(126, 32));
                send_item(c == etok_pkg::C_QUOTE ? etok_pkg::C_SPACE : c, 1'b0);
            end
        end
        if ($urandom_range(19) != 0)
            send_item(etok_pkg::C_QUOTE, 1'b0);
    endtask

    task automatic send_separator();
        int r;
        r = $urandom_range(9);
        if (r < 6) begin
            repeat ($urandom_range(3, 1))
                send_item($urandom_range(3) == 0
                              ? to_char(etok_pkg::C_TAB + $urandom_range(4))
                              : etok_pkg::C_SPACE,
                          1'b0);
        end else if (r < 9) begin
            send_item(pick_punct(), 1'b0);
        end else begin
            send_item(pick_noise(), 1'b0);
        end
    endtask

    task automatic send_message();
        int ntok;
        int kind;
        ntok = $urandom_range(6, 1);
        for (int t = 0; t < ntok; t++) begin
            kind = $urandom_range(99);
            if (kind < 30)
                send_ident();
            else if (kind < 55)
                send_number();
            else if (kind < 75)
                send_string();
            else if (kind < 90)
                send_item(pick_punct(), 1'b0);
            else
                send_item(pick_noise(), 1'b0);
            if (t < ntok - 1 || $urandom_range(1))
                send_separator();
        end
        if ($urandom_range(9) != 0)
            send_item(to_char($urandom_range(1114111, 0)), 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        // identifier from the top code point, closed by brackets
        send_item(C_TOP, 1'b0);
        send_item(to_char(etok_pkg::C_HIGH + 1), 1'b0);
        send_item(etok_pkg::C_OPEN, 1'b0);
        send_item(etok_pkg::C_CLOSE, 1'b0);
        // signed float that hits a second point, then end of message
        send_item(etok_pkg::C_MINUS, 1'b0);
        send_item(to_char(etok_pkg::C_DIGIT_LO + 1), 1'b0);
        send_item(etok_pkg::C_POINT, 1'b0);
        send_item(to_char(etok_pkg::C_DIGIT_LO + 5), 1'b0);
        send_item(etok_pkg::C_POINT, 1'b0);
        send_item('0, 1'b1);
        // doubled quote inside a string, then a comma
        repeat (4) send_item(etok_pkg::C_QUOTE, 1'b0);
        send_item(etok_pkg::C_COMMA, 1'b0);
        // empty string closed by equal
        send_item(etok_pkg::C_QUOTE, 1'b0);
        send_item(etok_pkg::C_QUOTE, 1'b0);
        send_item(etok_pkg::C_EQUAL, 1'b0);
        // zero code inside a string
        send_item(etok_pkg::C_QUOTE, 1'b0);
        send_item('0, 1'b0);
        send_item(C_TOP, 1'b1);
        // unterminated string
        send_item(etok_pkg::C_QUOTE, 1'b0);
        send_item(etok_pkg::C_LOWER_LO, 1'b0);
        send_item('0, 1'b1);
        // lone plus followed by a quote: no delimiter
        send_item(etok_pkg::C_PLUS, 1'b0);
        send_item(etok_pkg::C_QUOTE, 1'b0);
        send_item('0, 1'b1);
        // code 128 is not a letter
        send_item(etok_pkg::C_HIGH, 1'b0);
        send_item('0, 1'b1);
        wait_results_done();
    endtask

    task automatic test_token_stream(int gap_pct, int stall_pct, int count);
        int target;
        set_idling(gap_pct, stall_pct, 0);
        target = chars_sent + count;
        while (chars_sent < target)
            send_message();
        wait_results_done();
    endtask

    // Hold the output off long enough for the queue to fill and stall input.
    task automatic test_backpressure(int count);
        int target;
        set_idling(0, 0, HOLD_OFF_CYCLES);
        target = chars_sent + count;
        while (chars_sent < target)
            send_message();
        i_s_axis_tvalid <= 1'b0;
        while (hold_cycles != 0) @(posedge i_clk);
        @(negedge i_clk);
        wait_results_done();
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_cycles != 0) begin
            hold_cycles = hold_cycles - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic string fmt_result(etok_pkg::t_result r);
        return $sformatf("type %0d char %h has %b end %b err %b code %0d last %b",
                         r.token_type, r.token_char, r.has_char, r.token_end,
                         r.error_flag, r.error_code, r.run_end);
    endfunction

    task automatic report_mismatch(string what, etok_pkg::t_result exp,
                                   etok_pkg::t_result got);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("%0t %s: exp %s, got %s", $time, what, fmt_result(exp),
                     fmt_result(got));
    endtask

    always @(posedge i_clk) begin : result_check
        etok_pkg::t_result got;
        etok_pkg::t_result exp;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.token_type = o_m_axis_tuser;
            got.token_char = o_m_axis_tdata[20:0];
            got.has_char   = o_m_axis_tdata[21];
            got.token_end  = o_m_axis_tdata[22];
            got.error_flag = o_m_axis_tdata[23];
            got.error_code = o_m_axis_tdata[26:24];
            got.run_end    = o_m_axis_tlast;
            if (expected_tokens.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                exp = expected_tokens.pop_front();
                if (got.token_type !== exp.token_type || got.token_char !== exp.token_char
                    || got.has_char !== exp.has_char || got.token_end !== exp.token_end
                    || got.error_flag !== exp.error_flag
                    || got.error_code !== exp.error_code || got.run_end !== exp.run_end)
                    report_mismatch("result mismatch", exp, got);
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_token_stream(0, 0, 400);
        test_token_stream(87, 0, 300);
        test_token_stream(0, 87, 300);
        test_token_stream(13, 13, 500);
        test_backpressure(200);
        wait_results_done();
        while (expected_tokens.size() != 0)
            report_mismatch("missing result", expected_tokens.pop_front(), '0);
        if (mismatch_count == 0)
            $display("expression_tokenizer_test: PASS");
        else
            $display("expression_tokenizer_test: FAIL");
        $finish;
    end

endmodule
